/* hw/rtl/kslp_pkg.sv */
// ----------------------------------------------------------------------------
// kslp_pkg
// Types and constants shared by the key short/long press detector.
// ----------------------------------------------------------------------------
package kslp_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DIVIDER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd1;

	localparam logic [7:0]  SCAN_DIVIDER_RST  = 8'd21;
	localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1500;

	localparam logic [1:0] KEY_IDLE   = 2'd0;
	localparam logic [1:0] KEY_NET    = 2'd1;
	localparam logic [1:0] KEY_MODE   = 2'd2;
	localparam logic [1:0] KEY_BACKUP = 2'd3;

	typedef logic [1:0] key_code_t;

	typedef struct packed {
		logic        step;
		key_code_t   key;
		logic [31:0] ms;
		logic [15:0] long_ms;
	} scan_req_t;

	typedef struct packed {
		logic      hit;
		logic      long_press;
		key_code_t key;
	} scan_evt_t;

	typedef struct packed {
		logic      pending;
		logic      long_press;
		key_code_t key;
	} latched_evt_t;

endpackage

/* hw/rtl/kslp_key_if.sv */
// ----------------------------------------------------------------------------
// kslp_key_if
// Request channel carrying one millisecond tick with key levels and clear.
// ----------------------------------------------------------------------------
interface kslp_key_if;
	logic valid;
	logic ready;
	logic net_key_n;
	logic mode_key_n;
	logic backup_key_n;
	logic clear_event;

	modport source (output valid, net_key_n, mode_key_n, backup_key_n, clear_event,
		input ready);
	modport sink (input valid, net_key_n, mode_key_n, backup_key_n, clear_event,
		output ready);
endinterface

/* hw/rtl/kslp_evt_if.sv */
// ----------------------------------------------------------------------------
// kslp_evt_if
// Result channel carrying the latched key event after each tick.
// ----------------------------------------------------------------------------
interface kslp_evt_if;
	logic       valid;
	logic       ready;
	logic       event_pending;
	logic [1:0] event_key;
	logic       event_long;

	modport source (output valid, event_pending, event_key, event_long, input ready);
	modport sink (input valid, event_pending, event_key, event_long, output ready);
endinterface

/* hw/rtl/kslp_cfg_if.sv */
// ----------------------------------------------------------------------------
// kslp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface kslp_cfg_if;
	import kslp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/kslp_fsm.sv */
// ----------------------------------------------------------------------------
// kslp_fsm
// Press state machine with hold timer; steps once per scan.
// ----------------------------------------------------------------------------
module kslp_fsm
	import kslp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  scan_req_t req,
	output scan_evt_t evt
);

	localparam logic [2:0] ST_RELEASE   = 3'd0;
	localparam logic [2:0] ST_PRESS     = 3'd1;
	localparam logic [2:0] ST_PRESS_CHK = 3'd2;
	localparam logic [2:0] ST_LONG_CHK  = 3'd3;
	localparam logic [2:0] ST_WAIT_REL  = 3'd4;

	logic [2:0]  state_q, state_d;
	key_code_t   prev_q;
	logic [31:0] hold_q, hold_d, hold_eff, elapsed;
	logic        hold_vld_q, hold_vld_d;
	logic        same, long_hit;
	scan_evt_t   evt_d;

	always_comb begin
		same     = (req.key == prev_q);
		hold_eff = hold_vld_q ? hold_q : req.ms;
		elapsed  = req.ms - hold_eff;
		long_hit = (elapsed >= {16'd0, req.long_ms});
		state_d    = state_q;
		hold_d     = hold_q;
		hold_vld_d = hold_vld_q;
		evt_d      = '0;
		case (state_q)
			ST_PRESS: begin
				state_d = same ? ST_PRESS_CHK : ST_RELEASE;
			end
			ST_PRESS_CHK: begin
				if (same) begin
					state_d = ST_LONG_CHK;
				end else begin
					state_d   = ST_RELEASE;
					evt_d.hit = 1'b1;
					evt_d.key = prev_q;
				end
			end
			ST_LONG_CHK: begin
				if (same) begin
					hold_vld_d = 1'b1;
					hold_d     = hold_eff;
					if (long_hit) begin
						hold_vld_d       = 1'b0;
						hold_d           = '0;
						state_d          = ST_WAIT_REL;
						evt_d.hit        = 1'b1;
						evt_d.long_press = 1'b1;
						evt_d.key        = prev_q;
					end
				end else begin
					hold_vld_d = 1'b0;
					hold_d     = '0;
					state_d    = ST_RELEASE;
					evt_d.hit  = 1'b1;
					evt_d.key  = prev_q;
				end
			end
			ST_WAIT_REL: begin
				if (!same) state_d = ST_RELEASE;
			end
			default: begin
				state_d = same ? ST_RELEASE : ST_PRESS;
			end
		endcase
	end

	assign evt = req.step ? evt_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RELEASE;
			prev_q     <= KEY_IDLE;
			hold_q     <= '0;
			hold_vld_q <= 1'b0;
		end else if (req.step) begin
			state_q    <= state_d;
			prev_q     <= req.key;
			hold_q     <= hold_d;
			hold_vld_q <= hold_vld_d;
		end
	end

	ap_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELEASE || state_q == ST_PRESS || state_q == ST_PRESS_CHK
		|| state_q == ST_LONG_CHK || state_q == ST_WAIT_REL)
		else $error("press state out of range");
	ap_hold_only_long: assert property (@(posedge clk) disable iff (!arst_n)
		hold_vld_q |-> state_q == ST_LONG_CHK)
		else $error("hold timer running outside long-press check");
	ap_long_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		evt.long_press |=> state_q == ST_WAIT_REL)
		else $error("long event without wait-for-release");

endmodule

/* hw/rtl/key_short_long_press_detector.sv */
// ----------------------------------------------------------------------------
// key_short_long_press_detector
// Scans three active-low keys on a prescaled tick and latches short or long
// press events until cleared or replaced by a newer event.
// Result: registered, presented in the cycle after its request is accepted.
// Throughput: one request per cycle while events.ready is high; the result register frees as it is taken.
// Reset: divider 21, long time 1500 ms, machine in release, no event pending,
//        millisecond counter and prescaler at zero.
// ----------------------------------------------------------------------------
module key_short_long_press_detector
	import kslp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	kslp_cfg_if.sink   cfg,
	kslp_key_if.sink   keys,
	kslp_evt_if.source events
);

	logic [7:0]   div_q;
	logic [15:0]  long_ms_q;
	logic [7:0]   pre_q, pre_d;
	logic [8:0]   pre_inc;
	logic [31:0]  ms_q, ms_d;
	latched_evt_t lat_q, lat_d;
	logic         out_vld_q;
	latched_evt_t out_q;
	logic         acc, scan;
	key_code_t    cur_key;
	scan_req_t    req;
	scan_evt_t    evt;

	assign cfg.ready  = 1'b1;
	assign keys.ready = !out_vld_q || events.ready;
	assign acc        = keys.valid && keys.ready;

	always_comb begin
		if (!keys.net_key_n)         cur_key = KEY_NET;
		else if (!keys.mode_key_n)   cur_key = KEY_MODE;
		else if (!keys.backup_key_n) cur_key = KEY_BACKUP;
		else                         cur_key = KEY_IDLE;
		ms_d    = ms_q + 32'd1;
		pre_inc = {1'b0, pre_q} + 9'd1;
		scan    = (div_q == 8'd0) || (pre_inc >= {1'b0, div_q});
		pre_d   = scan ? 8'd0 : pre_inc[7:0];
		req.step    = acc && scan;
		req.key     = cur_key;
		req.ms      = ms_d;
		req.long_ms = long_ms_q;
	end

	always_comb begin
		if (evt.hit) begin
			lat_d.pending    = 1'b1;
			lat_d.long_press = evt.long_press;
			lat_d.key        = evt.key;
		end else if (keys.clear_event) begin
			lat_d = '0;
		end else begin
			lat_d = lat_q;
		end
	end

	kslp_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.evt    (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q     <= SCAN_DIVIDER_RST;
			long_ms_q <= LONG_PRESS_MS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_SCAN_DIVIDER:  div_q     <= cfg.data[7:0];
				CFG_LONG_PRESS_MS: long_ms_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q     <= '0;
			ms_q      <= '0;
			lat_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				pre_q     <= pre_d;
				ms_q      <= ms_d;
				lat_q     <= lat_d;
				out_vld_q <= 1'b1;
			end else if (events.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) out_q <= lat_d;
	end

	assign events.valid         = out_vld_q;
	assign events.event_pending = out_q.pending;
	assign events.event_key     = out_q.key;
	assign events.event_long    = out_q.long_press;

	ap_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_vld_q)
		else $error("accepted request produced no result");
	ap_ms_advance: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ms_q == $past(ms_q) + 32'd1)
		else $error("millisecond counter did not advance by one");
	ap_idle_event: assert property (@(posedge clk) disable iff (!arst_n)
		!lat_q.pending |-> (lat_q.key == KEY_IDLE && !lat_q.long_press))
		else $error("event fields set with nothing pending");
	ap_prescale_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && div_q != 8'd0) |=> pre_q < div_q || $past(pre_q) >= $past(div_q)
		|| $changed(div_q))
		else $error("prescaler passed divider");

endmodule
